### rtl/core/brf_pkg.sv
`default_nettype none
package brf_pkg;

  localparam int DEPTH_LOG2       = 12;
  localparam int MAX_READ_BYTES   = 64;
  localparam int WRITE_LANE_BYTES = 8;
  localparam int READ_LIMIT       = (MAX_READ_BYTES < 64) ? MAX_READ_BYTES : 64;

  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 104;

  localparam logic [2:0] CMD_WRITE   = 3'd0;
  localparam logic [2:0] CMD_READ    = 3'd1;
  localparam logic [2:0] CMD_PEEK    = 3'd2;
  localparam logic [2:0] CMD_ADV_RD  = 3'd3;
  localparam logic [2:0] CMD_ADV_WR  = 3'd4;
  localparam logic [2:0] CMD_RESET   = 3'd5;
  localparam logic [2:0] CMD_QUERY   = 3'd6;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_SHORT = 2'd1;
  localparam logic [1:0] ST_OVER  = 2'd2;

  localparam logic [0:0] REG_CAPACITY_LOG2 = 1'b0;

endpackage
`default_nettype wire

### rtl/core/byte_ring_fifo.sv
// A single-response command goes through S_EMIT and is presented from the output register.
// A write stores its bytes one by one in S_WR. A read or peek builds each beat of up to
// eight bytes in S_RD and S_RDWAIT and emits it from S_RDEMIT. Throughput: one request
// at a time, about one byte per cycle through the byte-wide store unless the output stalls.
// Reset clears the pointers and sets capacity_log2 to 12; store contents stay undefined.
`default_nettype none
module byte_ring_fifo (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 s_tvalid,
  output logic                                s_tready,
  // byte_count[11:0], allow_partial[12], write_data[76:13], zero fill
  input  wire  [brf_pkg::IN_DATA_W-1:0]       s_tdata,
  // cmd[2:0]
  input  wire  [2:0]                          s_tuser,
  output logic                                m_tvalid,
  input  wire                                 m_tready,
  // bytes_done[11:0], read_data[75:12], beat_bytes[79:76],
  // bytes_readable[91:80], bytes_writable[103:92]
  output logic [brf_pkg::OUT_DATA_W-1:0]      m_tdata,
  // status[1:0]
  output logic [1:0]                          m_tuser,
  output logic                                m_tlast,
  input  wire                                 psel,
  input  wire                                 penable,
  input  wire                                 pwrite,
  input  wire  [2:0]                          paddr,
  input  wire  [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);
  import brf_pkg::*;

  localparam int PW = DEPTH_LOG2;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_WR     = 3'd1;
  localparam logic [2:0] S_RD     = 3'd2;
  localparam logic [2:0] S_RDWAIT = 3'd3;
  localparam logic [2:0] S_RDEMIT = 3'd4;
  localparam logic [2:0] S_EMIT   = 3'd5;

  logic [7:0]    mem [0:(1<<PW)-1];
  logic [7:0]    mem_q;

  logic [2:0]    state;
  logic [3:0]    cap;
  logic [PW-1:0] read_pointer;
  logic [PW-1:0] write_pointer;
  logic [PW-1:0] addr;
  logic [63:0]   wdata;
  logic [63:0]   beat_word;
  logic [11:0]   done;
  logic [1:0]    status;
  logic [6:0]    remain;
  logic [2:0]    bidx;
  logic [2:0]    pidx;
  logic          pend;
  logic [3:0]    cnt;

  logic          out_valid;
  logic [1:0]    out_status;
  logic [11:0]   out_done;
  logic [63:0]   out_data;
  logic [3:0]    out_beat;
  logic          out_last;
  logic [11:0]   out_rd;
  logic [11:0]   out_wr;

  logic [3:0]    cap_cl;
  logic [PW-1:0] mask;
  logic [PW-1:0] rp;
  logic [PW-1:0] wp;
  logic [PW-1:0] readable;
  logic [PW-1:0] writable;
  logic [2:0]    in_cmd;
  logic [11:0]   in_count;
  logic          in_partial;
  logic [63:0]   in_wdata;
  logic          accept;
  logic          out_free;
  logic          load;
  logic [3:0]    len;
  logic [11:0]   n_wr;
  logic [11:0]   n_rd;

  always_comb begin
    if (cap < 4'd1) begin
      cap_cl = 4'd1;
    end else if (cap > 4'(DEPTH_LOG2)) begin
      cap_cl = 4'(DEPTH_LOG2);
    end else begin
      cap_cl = cap;
    end
  end

  assign mask     = PW'(({{PW{1'b0}}, 1'b1} << cap_cl) - 1'b1);
  assign rp       = read_pointer & mask;
  assign wp       = write_pointer & mask;
  assign readable = (wp - rp) & mask;
  assign writable = mask - readable;

  assign in_count   = s_tdata[11:0];
  assign in_partial = s_tdata[12];
  assign in_wdata   = s_tdata[76:13];
  assign in_cmd     = s_tuser;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !out_valid || m_tready;

  assign n_wr = (12'(writable) < in_count) ? 12'(writable) : in_count;
  assign n_rd = (12'(readable) < in_count) ? 12'(readable) : in_count;
  assign len  = (remain > 7'd8) ? 4'd8 : remain[3:0];
  assign load = out_free && (state == S_EMIT || state == S_RDEMIT);

  always_ff @(posedge clk) begin
    if (state == S_WR) begin
      mem[addr] <= wdata[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_RD) begin
      mem_q <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= 4'd12;
    end else if (psel && penable && pwrite && paddr[2] == REG_CAPACITY_LOG2) begin
      cap <= pwdata[3:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_CAPACITY_LOG2) ? {28'd0, cap} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      read_pointer  <= '0;
      write_pointer <= '0;
      pend          <= 1'b0;
    end else begin
      pend <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            status    <= ST_OK;
            done      <= 12'd0;
            beat_word <= 64'd0;
            bidx      <= 3'd0;
            wdata     <= in_wdata;
            state     <= S_EMIT;
            case (in_cmd)
              CMD_WRITE: begin
                if (in_count == 12'd0) begin
                  status <= ST_OK;
                end else if (in_count > 12'(WRITE_LANE_BYTES)) begin
                  status <= ST_OVER;
                end else if (writable == '0 ||
                             (12'(writable) < in_count && !in_partial)) begin
                  status <= ST_SHORT;
                end else begin
                  done          <= n_wr;
                  cnt           <= n_wr[3:0];
                  addr          <= wp;
                  write_pointer <= (wp + PW'(n_wr)) & mask;
                  state         <= S_WR;
                end
              end
              CMD_READ, CMD_PEEK: begin
                if (in_count == 12'd0) begin
                  status <= ST_OK;
                end else if (in_count > 12'(READ_LIMIT)) begin
                  status <= ST_OVER;
                end else if (readable == '0 ||
                             (12'(readable) < in_count && !in_partial)) begin
                  status <= ST_SHORT;
                end else begin
                  done   <= n_rd;
                  remain <= n_rd[6:0];
                  addr   <= rp;
                  if (in_cmd == CMD_READ) begin
                    read_pointer <= (rp + PW'(n_rd)) & mask;
                  end
                  state <= S_RD;
                end
              end
              CMD_ADV_RD: begin
                read_pointer <= (rp + PW'(in_count)) & mask;
              end
              CMD_ADV_WR: begin
                write_pointer <= (wp + PW'(in_count)) & mask;
              end
              CMD_RESET: begin
                read_pointer  <= '0;
                write_pointer <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        S_WR: begin
          addr  <= (addr + 1'b1) & mask;
          wdata <= wdata >> 8;
          cnt   <= cnt - 1'b1;
          if (cnt == 4'd1) begin
            state <= S_EMIT;
          end
        end
        S_RD: begin
          addr <= (addr + 1'b1) & mask;
          pend <= 1'b1;
          pidx <= bidx;
          bidx <= bidx + 1'b1;
          if (4'(bidx) + 4'd1 == len) begin
            state <= S_RDWAIT;
          end
        end
        S_RDWAIT: begin
          state <= S_RDEMIT;
        end
        S_RDEMIT: begin
          if (out_free) begin
            beat_word <= 64'd0;
            bidx      <= 3'd0;
            remain    <= remain - 7'(len);
            state     <= (remain <= 7'd8) ? S_IDLE : S_RD;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (pend) begin
        beat_word[8*pidx +: 8] <= mem_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_status <= status;
      out_done   <= done;
      out_rd     <= 12'(readable);
      out_wr     <= 12'(writable);
      if (state == S_RDEMIT) begin
        out_data <= beat_word;
        out_beat <= len;
        out_last <= (remain <= 7'd8);
      end else begin
        out_data <= 64'd0;
        out_beat <= 4'd0;
        out_last <= 1'b1;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_status;
  assign m_tlast  = out_last;
  assign m_tdata  = {out_wr, out_rd, out_beat, out_data, out_done};

endmodule
`default_nettype wire

### test/brf_checker.sv
`timescale 1ns / 100ps
module brf_checker (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            s_tvalid,
  input  wire                            s_tready,
  // byte_count[11:0], allow_partial[12], write_data[76:13], zero fill
  input  wire  [brf_pkg::IN_DATA_W-1:0]  s_tdata,
  // cmd[2:0]
  input  wire  [2:0]                     s_tuser,
  input  wire                            m_tvalid,
  input  wire                            m_tready,
  // bytes_done[11:0], read_data[75:12], beat_bytes[79:76],
  // bytes_readable[91:80], bytes_writable[103:92]
  input  wire  [brf_pkg::OUT_DATA_W-1:0] m_tdata,
  // status[1:0]
  input  wire  [1:0]                     m_tuser,
  input  wire                            m_tlast,
  input  wire                            psel,
  input  wire                            penable,
  input  wire                            pwrite,
  input  wire  [2:0]                     paddr,
  input  wire  [31:0]                    pwdata,
  input  wire                            pready,
  output int                             fail_count,
  output int                             outstanding,
  output int                             resp_count
);
  import brf_pkg::*;

  localparam logic [2:0] CAP_ADDR = 3'(4 * REG_CAPACITY_LOG2);

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] done;
    logic [63:0] data;
    logic [3:0]  beat;
    logic        last;
    logic [11:0] rd_avail;
    logic [11:0] wr_avail;
  } fifo_resp_t;

  fifo_resp_t expected_resp_q[$];
  logic [7:0] shadow_store [0:(1 << DEPTH_LOG2) - 1];
  int         rd_ptr;
  int         wr_ptr;
  logic [3:0] cap_log2;
  int         errors;
  int         checked;

  assign fail_count = errors;
  assign resp_count = checked;

  initial begin
    errors      = 0;
    checked     = 0;
    outstanding = 0;
    rd_ptr      = 0;
    wr_ptr      = 0;
    cap_log2    = 4'd12;
    for (int i = 0; i < (1 << DEPTH_LOG2); i++) shadow_store[i] = 8'h00;
  end

  function automatic int span_mask();
    int l;
    l = cap_log2;
    if (l < 1) l = 1;
    if (l > DEPTH_LOG2) l = DEPTH_LOG2;
    return (1 << l) - 1;
  endfunction

  // Fill state is always taken after the pointer update of the request.
  task automatic push_resp(input logic [1:0] status, input int done, input logic [63:0] data,
                           input int beat, input logic last);
    fifo_resp_t r;
    int         m;
    int         avail;
    m          = span_mask();
    avail      = ((wr_ptr & m) - (rd_ptr & m)) & m;
    r.status   = status;
    r.done     = 12'(done);
    r.data     = data;
    r.beat     = 4'(beat);
    r.last     = last;
    r.rd_avail = 12'(avail);
    r.wr_avail = 12'(m - avail);
    expected_resp_q.push_back(r);
  endtask

  task automatic predict_req(input logic [2:0] cmd, input logic [11:0] cnt, input logic partial,
                             input logic [63:0] wdata);
    int          m;
    int          rp;
    int          wp;
    int          avail;
    int          room;
    int          n;
    int          beats;
    int          len;
    logic [63:0] w;
    logic [63:0] words [8];
    int          lens [8];
    m     = span_mask();
    rp    = rd_ptr & m;
    wp    = wr_ptr & m;
    avail = (wp - rp) & m;
    room  = m - avail;
    case (cmd)
      CMD_WRITE: begin
        if (cnt == 0) begin
          push_resp(ST_OK, 0, 64'd0, 0, 1'b1);
        end else if (cnt > WRITE_LANE_BYTES) begin
          push_resp(ST_OVER, 0, 64'd0, 0, 1'b1);
        end else if (room == 0 || (room < cnt && !partial)) begin
          push_resp(ST_SHORT, 0, 64'd0, 0, 1'b1);
        end else begin
          n = (room < cnt) ? room : int'(cnt);
          for (int i = 0; i < n; i++) shadow_store[(wp + i) & m] = wdata[8*i +: 8];
          wr_ptr = (wp + n) & m;
          push_resp(ST_OK, n, 64'd0, 0, 1'b1);
        end
      end
      CMD_READ, CMD_PEEK: begin
        if (cnt == 0) begin
          push_resp(ST_OK, 0, 64'd0, 0, 1'b1);
        end else if (cnt > READ_LIMIT) begin
          push_resp(ST_OVER, 0, 64'd0, 0, 1'b1);
        end else if (avail == 0 || (avail < cnt && !partial)) begin
          push_resp(ST_SHORT, 0, 64'd0, 0, 1'b1);
        end else begin
          n     = (avail < cnt) ? avail : int'(cnt);
          beats = (n + 7) / 8;
          for (int b = 0; b < beats; b++) begin
            len = n - 8 * b;
            if (len > 8) len = 8;
            w = 64'd0;
            for (int i = 0; i < len; i++) w[8*i +: 8] = shadow_store[(rp + 8 * b + i) & m];
            words[b] = w;
            lens[b]  = len;
          end
          if (cmd == CMD_READ) rd_ptr = (rp + n) & m;
          for (int b = 0; b < beats; b++) push_resp(ST_OK, n, words[b], lens[b], b + 1 == beats);
        end
      end
      CMD_ADV_RD: begin
        rd_ptr = (rp + int'(cnt)) & m;
        push_resp(ST_OK, 0, 64'd0, 0, 1'b1);
      end
      CMD_ADV_WR: begin
        wr_ptr = (wp + int'(cnt)) & m;
        push_resp(ST_OK, 0, 64'd0, 0, 1'b1);
      end
      CMD_RESET: begin
        rd_ptr = 0;
        wr_ptr = 0;
        push_resp(ST_OK, 0, 64'd0, 0, 1'b1);
      end
      default: begin
        push_resp(ST_OK, 0, 64'd0, 0, 1'b1);
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      errors++;
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
    end
  endtask

  task automatic check_resp();
    fifo_resp_t want;
    checked++;
    if (expected_resp_q.size() == 0) begin
      errors++;
      $error("result with no request pending: status %0d, bytes_done %0d",
             m_tuser, m_tdata[11:0]);
    end else begin
      want = expected_resp_q.pop_front();
      check_field("status", want.status, m_tuser);
      check_field("bytes_done", want.done, m_tdata[11:0]);
      check_field("read_data", want.data, m_tdata[75:12]);
      check_field("beat_bytes", want.beat, m_tdata[79:76]);
      check_field("last", want.last, m_tlast);
      check_field("bytes_readable", want.rd_avail, m_tdata[91:80]);
      check_field("bytes_writable", want.wr_avail, m_tdata[103:92]);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      expected_resp_q.delete();
      rd_ptr   = 0;
      wr_ptr   = 0;
      cap_log2 = 4'd12;
    end else begin
      if (psel && penable && pwrite && pready && paddr == CAP_ADDR) cap_log2 = pwdata[3:0];
      if (m_tvalid && m_tready) check_resp();
      if (s_tvalid && s_tready) predict_req(s_tuser, s_tdata[11:0], s_tdata[12], s_tdata[76:13]);
    end
    outstanding <= expected_resp_q.size();
  end

endmodule

### test/testbench.sv
`timescale 1ns / 100ps
module testbench;
  import brf_pkg::*;

  localparam logic [2:0] CMD_SPARE   = 3'd7;
  localparam logic [2:0] CAP_ADDR    = 3'(4 * REG_CAPACITY_LOG2);
  localparam int         STALL_LIMIT = 3000;
  localparam int         HOLD_CYCLES = 300;

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata  = '0;
  logic [2:0]            s_tuser  = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [1:0]            m_tuser;
  logic                  m_tlast;
  logic                  psel     = 1'b0;
  logic                  penable  = 1'b0;
  logic                  pwrite   = 1'b0;
  logic [2:0]            paddr    = '0;
  logic [31:0]           pwdata   = '0;
  logic [31:0]           prdata;
  logic                  pready;

  int fail_count;
  int outstanding;
  int resp_count;
  int tx_idle_pct  = 0;
  int rx_idle_pct  = 0;
  int hold_reqs    = 0;
  int hold_seen    = 0;
  int hold_left    = 0;
  int idle_cycles  = 0;
  int req_count    = 0;
  int cap_settings = 0;

  byte_ring_fifo u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  brf_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .pready      (pready),
    .fail_count  (fail_count),
    .outstanding (outstanding),
    .resp_count  (resp_count)
  );

  always #6 clk = ~clk;

  // A hold request makes the receiver refuse results for a long stretch.
  always @(posedge clk) begin
    if (hold_seen != hold_reqs) begin
      hold_seen <= hold_reqs;
      hold_left <= HOLD_CYCLES;
      m_tready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_req(input logic [2:0] c, input logic [11:0] n, input logic partial,
                          input logic [63:0] data);
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= c;
    s_tdata  <= {3'b000, data, partial, n};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    req_count++;
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic send_random_req();
    int          pick;
    int          sel;
    logic [2:0]  c;
    logic [11:0] n;
    logic        partial;
    pick    = $urandom_range(99);
    sel     = $urandom_range(19);
    partial = ($urandom_range(9) < 7);
    if (pick < 42) begin
      c = CMD_WRITE;
      n = (sel == 0) ? 12'd0 : (sel == 1) ? 12'($urandom_range(4095, 9))
                             : 12'($urandom_range(8, 1));
    end else if (pick < 80) begin
      c = (pick < 68) ? CMD_READ : CMD_PEEK;
      n = (sel == 0) ? 12'd0 : (sel == 1) ? 12'($urandom_range(4095, 65))
                             : 12'($urandom_range(64, 1));
    end else begin
      case ($urandom_range(4))
        0:       c = CMD_ADV_RD;
        1:       c = CMD_ADV_WR;
        2:       c = CMD_RESET;
        3:       c = CMD_QUERY;
        default: c = CMD_SPARE;
      endcase
      n = ($urandom_range(1) == 0) ? 12'($urandom_range(4095)) : 12'($urandom_range(8));
    end
    send_req(c, n, partial, {$urandom, $urandom});
    if ($urandom_range(24) == 0) wait_drained();
  endtask

  task automatic run_phase(input logic [3:0] cap, input int items);
    wait_drained();
    repeat (4) @(posedge clk);
    apb_write(CAP_ADDR, {28'd0, cap});
    cap_settings++;
    repeat (items) send_random_req();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst         <= 1'b0;
    tx_idle_pct = 15;
    rx_idle_pct = 70;

    send_req(CMD_QUERY, 12'd0, 1'b0, 64'd0);
    send_req(CMD_SPARE, 12'd3, 1'b1, 64'd0);
    send_req(CMD_WRITE, 12'd0, 1'b1, {$urandom, $urandom});
    send_req(CMD_READ, 12'd0, 1'b1, 64'd0);
    send_req(CMD_PEEK, 12'd0, 1'b0, 64'd0);
    send_req(CMD_WRITE, 12'd9, 1'b1, {$urandom, $urandom});
    send_req(CMD_WRITE, 12'hFFF, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
    send_req(CMD_READ, 12'd65, 1'b1, 64'd0);
    send_req(CMD_PEEK, 12'hFFF, 1'b1, 64'd0);
    send_req(CMD_WRITE, 12'd8, 1'b0, {$urandom, $urandom});
    send_req(CMD_PEEK, 12'd8, 1'b0, 64'd0);
    send_req(CMD_READ, 12'd8, 1'b0, 64'd0);
    send_req(CMD_READ, 12'd1, 1'b1, 64'd0);
    send_req(CMD_PEEK, 12'd1, 1'b1, 64'd0);
    send_req(CMD_WRITE, 12'd8, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_req(CMD_WRITE, 12'd8, 1'b0, 64'd0);
    for (int k = 0; k < 6; k++) send_req(CMD_WRITE, 12'd8, 1'b0, {$urandom, $urandom});
    send_req(CMD_READ, 12'd64, 1'b0, 64'd0);
    send_req(CMD_WRITE, 12'd5, 1'b0, {$urandom, $urandom});
    send_req(CMD_READ, 12'd20, 1'b0, 64'd0);
    send_req(CMD_READ, 12'd20, 1'b1, 64'd0);
    send_req(CMD_ADV_WR, 12'hFFF, 1'b0, 64'd0);
    send_req(CMD_ADV_RD, 12'd1, 1'b0, 64'd0);
    send_req(CMD_RESET, 12'd0, 1'b0, 64'd0);
    send_req(CMD_QUERY, 12'd0, 1'b0, 64'd0);

    run_phase(4'd15, 0);
    send_req(CMD_QUERY, 12'd0, 1'b0, 64'd0);
    send_req(CMD_WRITE, 12'd8, 1'b0, {$urandom, $urandom});
    send_req(CMD_READ, 12'd8, 1'b0, 64'd0);

    run_phase(4'd3, 0);
    send_req(CMD_WRITE, 12'd8, 1'b0, {$urandom, $urandom});
    send_req(CMD_WRITE, 12'd8, 1'b1, {$urandom, $urandom});
    send_req(CMD_WRITE, 12'd1, 1'b1, {$urandom, $urandom});
    send_req(CMD_PEEK, 12'd8, 1'b1, 64'd0);
    send_req(CMD_READ, 12'd8, 1'b0, 64'd0);
    send_req(CMD_RESET, 12'd0, 1'b0, 64'd0);

    // Random phases use at most 256 bytes, so the low 256 store bytes are written first.
    run_phase(4'd12, 0);
    for (int k = 0; k < 32; k++) send_req(CMD_WRITE, 12'd8, 1'b1, {$urandom, $urandom});

    run_phase(4'd1, 40);
    run_phase(4'd0, 40);
    tx_idle_pct = 70;
    rx_idle_pct = 15;
    run_phase(4'd8, 40);
    run_phase(4'd3, 40);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_phase(4'($urandom_range(8, 2)), 24);
    hold_reqs <= hold_reqs + 1;
    repeat (20) send_random_req();
    run_phase(4'd8, 36);

    wait_drained();
    repeat (20) @(posedge clk);
    $display("Sent %0d requests, a preload of the low store bytes among them, over %0d capacity settings.",
             req_count, cap_settings);
    $display("Compared %0d results field by field against the predicted FIFO contents.",
             resp_count);
    if (fail_count == 0 && outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/brf_pkg.sv
rtl/core/byte_ring_fifo.sv
test/brf_checker.sv
test/testbench.sv
